@@ sv/gdad_pkg.sv @@
package gdad_pkg;

  // field widths
  localparam int unsigned INCREMENT_WIDTH = 16;
  localparam int unsigned YEAR_W  = 14;
  localparam int unsigned MONTH_W = 4;
  localparam int unsigned DAY_W   = 5;
  localparam int unsigned INC_W   = 16;

  // internal year can run past the 14-bit field before saturation
  localparam int unsigned YEAR_IW = YEAR_W + 1;
  // remaining day count holds day + increment
  localparam int unsigned REM_W   = INCREMENT_WIDTH + 1;

  // stream bus widths, padded to whole bytes
  localparam int unsigned S_FIELDS_W = YEAR_W + MONTH_W + DAY_W + INC_W;
  localparam int unsigned S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int unsigned M_FIELDS_W = YEAR_W + MONTH_W + DAY_W + 1;
  localparam int unsigned M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  // calendar constants
  localparam logic [YEAR_W-1:0]  YEAR_MAX     = YEAR_W'(9999);
  localparam logic [8:0]         CYCLE_400    = 9'd400;
  localparam logic [6:0]         CYCLE_100    = 7'd100;
  localparam logic [MONTH_W-1:0] MONTH_JAN    = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB    = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_APR    = MONTH_W'(4);
  localparam logic [MONTH_W-1:0] MONTH_JUN    = MONTH_W'(6);
  localparam logic [MONTH_W-1:0] MONTH_SEP    = MONTH_W'(9);
  localparam logic [MONTH_W-1:0] MONTH_NOV    = MONTH_W'(11);
  localparam logic [MONTH_W-1:0] MONTH_DEC    = MONTH_W'(12);
  localparam logic [DAY_W-1:0]   DAYS_LEAP    = DAY_W'(29);
  localparam logic [DAY_W-1:0]   DAYS_COMMON  = DAY_W'(28);
  localparam logic [DAY_W-1:0]   DAYS_SHORT   = DAY_W'(30);
  localparam logic [DAY_W-1:0]   DAYS_LONG    = DAY_W'(31);

  // days in a month, month already clamped to 1..12
  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                 input logic leap);
    logic [DAY_W-1:0] len;
    case (month)
      MONTH_FEB: len = leap ? DAYS_LEAP : DAYS_COMMON;
      MONTH_APR, MONTH_JUN, MONTH_SEP, MONTH_NOV: len = DAYS_SHORT;
      default: len = DAYS_LONG;
    endcase
    return len;
  endfunction

endpackage

@@ sv/gregorian_date_add_days_unit.sv @@
// Gregorian date plus a day count.
// Input beats on s_axis carry a start date (year, month, day) and a day
// increment; each gives exactly one result beat on m_axis with the date
// that many days later and a flag set when the year passed 9999 and was
// clamped. The all-zero date passes through as all zeros.
// The year is first reduced modulo 400 and then 100 by repeated
// subtraction, then the day count is walked one month at a time until it
// fits the current month, and the result is loaded into the output register.
// The all-zero date skips the reduction and the walk. The largest increment
// walks about 2150 months, through one shared subtract and compare.
// s_axis_tready is high only while the sequencer is idle, so the next input
// beat can be taken the cycle after a result is loaded. The output register lets
// a new item be taken and worked on while the last result still waits. If
// the receiver stalls, the finished result is held until the output register
// frees up.
// Reset clears the sequencer and the output valid; no result is pending.
module gregorian_date_add_days_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // start_year, start_month, start_day, day_increment, zero pad
  input  logic [gdad_pkg::S_TDATA_W-1:0]  s_axis_tdata,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // result_year, result_month, result_day, year_overflow
  output logic [gdad_pkg::M_TDATA_W-1:0]  m_axis_tdata
);
  import gdad_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MOD400,
    ST_MOD100,
    ST_WALK,
    ST_FINISH
  } state_e;

  state_e               state_q;
  logic [YEAR_IW-1:0]   year_q;
  logic [MONTH_W-1:0]   month_q;
  logic [DAY_W-1:0]     day_q;
  logic [REM_W-1:0]     rem_q;
  logic [YEAR_IW-1:0]   mod_q;
  logic [8:0]           r400_q;
  logic [6:0]           r100_q;
  logic                 out_valid_q;
  logic [YEAR_W-1:0]    out_year_q;
  logic [MONTH_W-1:0]   out_month_q;
  logic [DAY_W-1:0]     out_day_q;
  logic                 out_ovf_q;

  // input field split
  logic [YEAR_W-1:0]    in_year;
  logic [MONTH_W-1:0]   in_month;
  logic [DAY_W-1:0]     in_day;
  logic [INC_W-1:0]     in_inc;
  logic [MONTH_W-1:0]   in_month_clamped;
  logic                 in_null;
  logic                 s_fire;

  assign in_year  = s_axis_tdata[YEAR_W-1:0];
  assign in_month = s_axis_tdata[YEAR_W +: MONTH_W];
  assign in_day   = s_axis_tdata[YEAR_W+MONTH_W +: DAY_W];
  assign in_inc   = s_axis_tdata[YEAR_W+MONTH_W+DAY_W +: INC_W];
  assign in_null  = (in_year == '0) && (in_month == '0) && (in_day == '0);
  assign s_fire   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_month_clamped = in_month;
    if (in_month == '0) begin
      in_month_clamped = MONTH_JAN;
    end else if (in_month > MONTH_DEC) begin
      in_month_clamped = MONTH_DEC;
    end
  end

  // shared reduction subtractor, divisor picked by state
  logic [YEAR_IW-1:0]   mod_div;
  logic                 mod_ge;
  logic [YEAR_IW-1:0]   mod_diff;

  assign mod_div  = (state_q == ST_MOD400) ? YEAR_IW'(CYCLE_400) : YEAR_IW'(CYCLE_100);
  assign mod_ge   = (mod_q >= mod_div);
  assign mod_diff = mod_q - mod_div;

  // month length and the shared walk compare and subtract
  logic                 leap;
  logic [DAY_W-1:0]     cur_len;
  logic                 rem_fits;
  logic [REM_W-1:0]     rem_next;

  assign leap     = ((year_q[1:0] == 2'b00) && (r100_q != '0)) || (r400_q == '0);
  assign cur_len  = month_len(month_q, leap);
  assign rem_fits = (rem_q <= REM_W'(cur_len));
  assign rem_next = rem_q - REM_W'(cur_len);

  // saturation at the output
  logic                 sat;
  assign sat = (year_q > YEAR_IW'(YEAR_MAX));

  // output register load when the finished result may move in
  logic                 out_load;
  assign out_load = (state_q == ST_FINISH) && (!out_valid_q || m_axis_tready);

  // sequencer, working registers and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      year_q      <= '0;
      month_q     <= '0;
      day_q       <= '0;
      rem_q       <= '0;
      mod_q       <= '0;
      r400_q      <= '0;
      r100_q      <= '0;
      out_valid_q <= 1'b0;
      out_year_q  <= '0;
      out_month_q <= '0;
      out_day_q   <= '0;
      out_ovf_q   <= 1'b0;
    end else begin
      // output valid set on load, cleared when the beat is taken
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (s_fire) begin
            year_q  <= YEAR_IW'(in_year);
            mod_q   <= YEAR_IW'(in_year);
            month_q <= in_null ? '0 : in_month_clamped;
            day_q   <= in_day;
            rem_q   <= REM_W'(in_day) + REM_W'(in_inc[INCREMENT_WIDTH-1:0]);
            if (in_null) begin
              state_q <= ST_FINISH;
            end else begin
              state_q <= ST_MOD400;
            end
          end
        end
        ST_MOD400: begin
          if (mod_ge) begin
            mod_q <= mod_diff;
          end else begin
            r400_q  <= mod_q[8:0];
            state_q <= ST_MOD100;
          end
        end
        ST_MOD100: begin
          if (mod_ge) begin
            mod_q <= mod_diff;
          end else begin
            r100_q  <= mod_q[6:0];
            state_q <= ST_WALK;
          end
        end
        ST_WALK: begin
          if (rem_fits) begin
            day_q   <= rem_q[DAY_W-1:0];
            state_q <= ST_FINISH;
          end else begin
            rem_q <= rem_next;
            // step to the next month, rolling the year residues on new year
            if (month_q == MONTH_DEC) begin
              month_q <= MONTH_JAN;
              year_q  <= year_q + YEAR_IW'(1);
              r400_q  <= (r400_q == CYCLE_400 - 9'd1) ? '0 : r400_q + 9'd1;
              r100_q  <= (r100_q == CYCLE_100 - 7'd1) ? '0 : r100_q + 7'd1;
            end else begin
              month_q <= month_q + MONTH_W'(1);
            end
          end
        end
        ST_FINISH: begin
          if (out_load) begin
            out_year_q  <= sat ? YEAR_MAX : year_q[YEAR_W-1:0];
            out_month_q <= month_q;
            out_day_q   <= day_q;
            out_ovf_q   <= sat;
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'({out_ovf_q, out_day_q, out_month_q, out_year_q});

  // year residues stay in range while walking
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> (r400_q < CYCLE_400) && (r100_q < CYCLE_100))
    else $error("year residue out of range");

  // residues agree with each other
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WALK) |-> ((r400_q == '0) ? (r100_q == '0) : 1'b1))
    else $error("year residues disagree");

  // overflow only with a clamped year
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_ovf_q |-> (out_year_q == YEAR_MAX))
    else $error("overflow without saturated year");

  // a zero month only for the null date
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_month_q == '0) |->
      (out_year_q == '0) && (out_day_q == '0) && !out_ovf_q)
    else $error("zero month on a non-null result");

  // a walked result never lands past december
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (out_month_q <= MONTH_DEC))
    else $error("result month out of range");

endmodule

@@ tb/tb_gregorian_date_add_days_unit.sv @@
`timescale 1ns / 100ps

module tb_gregorian_date_add_days_unit;
  import gdad_pkg::*;

  // bit offsets inside the stream beats
  localparam int unsigned OFS_MONTH = YEAR_W;
  localparam int unsigned OFS_DAY   = YEAR_W + MONTH_W;
  localparam int unsigned OFS_INC   = YEAR_W + MONTH_W + DAY_W;
  localparam int unsigned OFS_OVF   = YEAR_W + MONTH_W + DAY_W;

  localparam int unsigned RANDOM_DATES  = 250;
  localparam int unsigned STALL_LIMIT   = 20000;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned HOLD_AFTER    = 120;
  localparam int unsigned DRAIN_CYCLES  = 100;

  typedef enum int {
    PH_STEADY,
    PH_SEND_GAPS,
    PH_RECV_STALLS,
    PH_BOTH_GAPS
  } idle_phase_e;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic [INC_W-1:0]   inc;
  } start_date_t;

  typedef struct {
    logic [YEAR_W-1:0]  year;
    logic [MONTH_W-1:0] month;
    logic [DAY_W-1:0]   day;
    logic               ovf;
  } end_date_t;

  logic clk_i;
  logic rst_ni;
  logic s_axis_tvalid;
  logic s_axis_tready;
  // start_year, start_month, start_day, day_increment, zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid;
  logic m_axis_tready;
  // result_year, result_month, result_day, year_overflow
  logic [M_TDATA_W-1:0] m_axis_tdata;

  start_date_t pending_dates[$];
  end_date_t   due_dates[$];
  int unsigned total_dates;
  int unsigned beats_in;
  int unsigned fail_count;
  int unsigned quiet_cycles;
  int unsigned hold_left;
  bit          hold_used;
  bit          in_taken;

  gregorian_date_add_days_unit i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  // 2 ns clock
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  function automatic bit is_leap(int yr);
    return (yr % 400 == 0) || ((yr % 4 == 0) && (yr % 100 != 0));
  endfunction

  function automatic int days_in_month(int yr, int mon);
    if (mon == 2) return is_leap(yr) ? 29 : 28;
    if (mon == 4 || mon == 6 || mon == 9 || mon == 11) return 30;
    return 31;
  endfunction

  // date reached after walking the increment forward month by month
  function automatic end_date_t later_date(start_date_t sd);
    end_date_t ed;
    int yr;
    int mon;
    int left;
    int len;
    yr   = int'(sd.year);
    mon  = int'(sd.month);
    left = int'(sd.inc) & ((1 << INCREMENT_WIDTH) - 1);
    ed   = '{year: '0, month: '0, day: '0, ovf: 1'b0};
    if (sd.year == 0 && sd.month == 0 && sd.day == 0) return ed;
    if (mon == 0) mon = 1;
    if (mon > 12) mon = 12;
    len = days_in_month(yr, mon);
    if (int'(sd.day) + left <= len) begin
      left = int'(sd.day) + left;
    end else begin
      // spill the excess into the following months
      left = left + int'(sd.day) - len;
      do begin
        mon++;
        if (mon > 12) begin
          mon = 1;
          yr++;
        end
        len = days_in_month(yr, mon);
        if (left > len) left -= len;
        else break;
      end while (1);
    end
    if (yr > int'(YEAR_MAX)) begin
      yr     = int'(YEAR_MAX);
      ed.ovf = 1'b1;
    end
    ed.year  = YEAR_W'(yr);
    ed.month = MONTH_W'(mon);
    ed.day   = DAY_W'(left);
    return ed;
  endfunction

  // idle percentage for one side in the current phase
  function automatic int unsigned idle_pct(bit recv_side);
    idle_phase_e ph;
    ph = idle_phase_e'((beats_in * 8 / (total_dates + 1)) % 4);
    case (ph)
      PH_SEND_GAPS:   return recv_side ? 0 : 73;
      PH_RECV_STALLS: return recv_side ? 73 : 0;
      PH_BOTH_GAPS:   return 21;
      default:        return 0;
    endcase
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic queue_date(int yr, int mon, int dy, int inc);
    start_date_t sd;
    sd = '{year: YEAR_W'(yr), month: MONTH_W'(mon), day: DAY_W'(dy), inc: INC_W'(inc)};
    pending_dates = {pending_dates, sd};
  endtask

  // driver: offers the next pending start date at the falling edge
  always @(negedge clk_i) begin : drive_dates
    start_date_t nxt;
    if (rst_ni && (!s_axis_tvalid || in_taken)) begin
      if (pending_dates.size() != 0 &&
          (hold_left != 0 || $urandom_range(99) >= idle_pct(1'b0))) begin
        nxt = pending_dates.pop_front();
        s_axis_tdata  <= S_TDATA_W'({nxt.inc, nxt.day, nxt.month, nxt.year});
        s_axis_tvalid <= 1'b1;
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // receiver ready, forced low during the long hold
  always @(negedge clk_i) begin
    m_axis_tready <= rst_ni && hold_left == 0 && $urandom_range(99) >= idle_pct(1'b1);
  end

  // one long receiver hold so the block backs up onto its input
  always @(negedge clk_i) begin
    if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_used && beats_in >= HOLD_AFTER) begin
      hold_left <= HOLD_CYCLES;
      hold_used <= 1'b1;
    end
  end

  // monitor: predicts on every input beat, checks every result beat
  always @(posedge clk_i) begin : watch_beats
    start_date_t sd;
    end_date_t   got;
    end_date_t   want;
    in_taken = 1'b0;
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) begin
        sd.year  = s_axis_tdata[0 +: YEAR_W];
        sd.month = s_axis_tdata[OFS_MONTH +: MONTH_W];
        sd.day   = s_axis_tdata[OFS_DAY +: DAY_W];
        sd.inc   = s_axis_tdata[OFS_INC +: INC_W];
        due_dates = {due_dates, later_date(sd)};
        in_taken = 1'b1;
        beats_in++;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got.year  = m_axis_tdata[0 +: YEAR_W];
        got.month = m_axis_tdata[OFS_MONTH +: MONTH_W];
        got.day   = m_axis_tdata[OFS_DAY +: DAY_W];
        got.ovf   = m_axis_tdata[OFS_OVF];
        if (due_dates.size() == 0) begin
          report_mismatch("unexpected result beat, year", int'(got.year), -1);
        end else begin
          want = due_dates.pop_front();
          if (got.year !== want.year)
            report_mismatch("result_year", int'(got.year), int'(want.year));
          if (got.month !== want.month)
            report_mismatch("result_month", int'(got.month), int'(want.month));
          if (got.day !== want.day)
            report_mismatch("result_day", int'(got.day), int'(want.day));
          if (got.ovf !== want.ovf)
            report_mismatch("year_overflow", int'(got.ovf), int'(want.ovf));
        end
      end
    end
  end

  // watchdog on cycles without any accepted beat
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout after %0d quiet cycles", quiet_cycles);
        $display("gregorian_date_add_days_unit verification failed");
        $finish;
      end
    end
  end

  initial begin : run_test
    int sel;
    int yr;
    int mon;
    int dy;
    int inc;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    m_axis_tready = 1'b0;
    beats_in      = 0;
    fail_count    = 0;
    quiet_cycles  = 0;
    hold_left     = 0;
    hold_used     = 1'b0;
    in_taken      = 1'b0;

    // directed corners
    queue_date(0, 0, 0, 0);           // null date
    queue_date(0, 0, 0, 65535);       // null date, largest step
    queue_date(0, 1, 1, 59);          // year zero is leap
    queue_date(0, 0, 5, 40);          // month zero with nonzero day
    queue_date(2021, 0, 10, 0);
    queue_date(2021, 13, 20, 15);     // months past december
    queue_date(2021, 15, 31, 1);
    queue_date(2023, 6, 0, 0);        // day zero, no step
    queue_date(2023, 6, 0, 1);
    queue_date(2023, 2, 31, 0);       // day past month end
    queue_date(2023, 2, 31, 1);
    queue_date(2023, 4, 31, 3);
    queue_date(2000, 2, 28, 1);       // 400-year leap
    queue_date(1900, 2, 28, 1);       // century, not leap
    queue_date(2024, 2, 28, 1);
    queue_date(2024, 12, 31, 1);
    queue_date(9999, 12, 31, 0);
    queue_date(9999, 12, 31, 1);      // saturates the year
    queue_date(16383, 15, 31, 0);     // year above range
    queue_date(1, 1, 1, 65535);
    queue_date(9999, 1, 1, 65535);
    queue_date(8192, 8, 16, 32768);

    // random dates, mostly well formed
    for (int n = 0; n < RANDOM_DATES; n++) begin
      sel = $urandom_range(99);
      if (sel < 3) begin
        queue_date(0, 0, 0, $urandom_range(65535));
      end else begin
        sel = $urandom_range(99);
        if (sel < 80) yr = $urandom_range(9999, 1);
        else if (sel < 88) yr = $urandom_range(9999, 9990);
        else yr = $urandom_range(16383);
        mon = ($urandom_range(99) < 90) ? $urandom_range(12, 1) : $urandom_range(15);
        if ($urandom_range(99) < 85)
          dy = $urandom_range(days_in_month(yr, (mon == 0) ? 1 : (mon > 12) ? 12 : mon), 1);
        else
          dy = $urandom_range(31);
        sel = $urandom_range(99);
        if (sel < 60) inc = $urandom_range(400);
        else if (sel < 85) inc = $urandom_range(4000);
        else inc = $urandom_range(65535);
        queue_date(yr, mon, dy, inc);
      end
    end
    total_dates = pending_dates.size();

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // drain everything, then let the pipeline settle
    while (pending_dates.size() != 0 || s_axis_tvalid || due_dates.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (m_axis_tvalid || due_dates.size() != 0) begin
      report_mismatch("results left over", int'(due_dates.size()), 0);
    end

    if (fail_count == 0) begin
      $display("gregorian_date_add_days_unit verification clean");
    end else begin
      $display("gregorian_date_add_days_unit verification failed");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/gdad_pkg.sv
sv/gregorian_date_add_days_unit.sv
tb/tb_gregorian_date_add_days_unit.sv
